FILE: design/aes_pkg.sv
// Package with the AES-128 types, S-box, round constants and round functions.
`timescale 1ns / 1ps
package aes_pkg;

  typedef logic [127:0] blk_t;

  localparam int NumRounds = 10;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7C, 8'h77, 8'h7B, 8'hF2, 8'h6B, 8'h6F, 8'hC5, 8'h30, 8'h01, 8'h67, 8'h2B,
    8'hFE, 8'hD7, 8'hAB, 8'h76,
    8'hCA, 8'h82, 8'hC9, 8'h7D, 8'hFA, 8'h59, 8'h47, 8'hF0, 8'hAD, 8'hD4, 8'hA2, 8'hAF,
    8'h9C, 8'hA4, 8'h72, 8'hC0,
    8'hB7, 8'hFD, 8'h93, 8'h26, 8'h36, 8'h3F, 8'hF7, 8'hCC, 8'h34, 8'hA5, 8'hE5, 8'hF1,
    8'h71, 8'hD8, 8'h31, 8'h15,
    8'h04, 8'hC7, 8'h23, 8'hC3, 8'h18, 8'h96, 8'h05, 8'h9A, 8'h07, 8'h12, 8'h80, 8'hE2,
    8'hEB, 8'h27, 8'hB2, 8'h75,
    8'h09, 8'h83, 8'h2C, 8'h1A, 8'h1B, 8'h6E, 8'h5A, 8'hA0, 8'h52, 8'h3B, 8'hD6, 8'hB3,
    8'h29, 8'hE3, 8'h2F, 8'h84,
    8'h53, 8'hD1, 8'h00, 8'hED, 8'h20, 8'hFC, 8'hB1, 8'h5B, 8'h6A, 8'hCB, 8'hBE, 8'h39,
    8'h4A, 8'h4C, 8'h58, 8'hCF,
    8'hD0, 8'hEF, 8'hAA, 8'hFB, 8'h43, 8'h4D, 8'h33, 8'h85, 8'h45, 8'hF9, 8'h02, 8'h7F,
    8'h50, 8'h3C, 8'h9F, 8'hA8,
    8'h51, 8'hA3, 8'h40, 8'h8F, 8'h92, 8'h9D, 8'h38, 8'hF5, 8'hBC, 8'hB6, 8'hDA, 8'h21,
    8'h10, 8'hFF, 8'hF3, 8'hD2,
    8'hCD, 8'h0C, 8'h13, 8'hEC, 8'h5F, 8'h97, 8'h44, 8'h17, 8'hC4, 8'hA7, 8'h7E, 8'h3D,
    8'h64, 8'h5D, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4F, 8'hDC, 8'h22, 8'h2A, 8'h90, 8'h88, 8'h46, 8'hEE, 8'hB8, 8'h14,
    8'hDE, 8'h5E, 8'h0B, 8'hDB,
    8'hE0, 8'h32, 8'h3A, 8'h0A, 8'h49, 8'h06, 8'h24, 8'h5C, 8'hC2, 8'hD3, 8'hAC, 8'h62,
    8'h91, 8'h95, 8'hE4, 8'h79,
    8'hE7, 8'hC8, 8'h37, 8'h6D, 8'h8D, 8'hD5, 8'h4E, 8'hA9, 8'h6C, 8'h56, 8'hF4, 8'hEA,
    8'h65, 8'h7A, 8'hAE, 8'h08,
    8'hBA, 8'h78, 8'h25, 8'h2E, 8'h1C, 8'hA6, 8'hB4, 8'hC6, 8'hE8, 8'hDD, 8'h74, 8'h1F,
    8'h4B, 8'hBD, 8'h8B, 8'h8A,
    8'h70, 8'h3E, 8'hB5, 8'h66, 8'h48, 8'h03, 8'hF6, 8'h0E, 8'h61, 8'h35, 8'h57, 8'hB9,
    8'h86, 8'hC1, 8'h1D, 8'h9E,
    8'hE1, 8'hF8, 8'h98, 8'h11, 8'h69, 8'hD9, 8'h8E, 8'h94, 8'h9B, 8'h1E, 8'h87, 8'hE9,
    8'hCE, 8'h55, 8'h28, 8'hDF,
    8'h8C, 8'hA1, 8'h89, 8'h0D, 8'hBF, 8'hE6, 8'h42, 8'h68, 8'h41, 8'h99, 8'h2D, 8'h0F,
    8'hB0, 8'h54, 8'hBB, 8'h16
  };

  localparam logic [7:0] RCON [NumRounds] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1B, 8'h36
  };

  // Register addresses (byte addresses, 64-bit registers).
  localparam logic [3:0] AddrKeyHigh = 4'h0;
  localparam logic [3:0] AddrKeyLow  = 4'h8;

  // Byte i of a block sits at bits 127-8i down to 120-8i.
  function automatic logic [7:0] get_byte(input blk_t b, input int i);
    return b[127 - 8 * i -: 8];
  endfunction

  function automatic logic [7:0] gf_double(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1B : 8'h00);
  endfunction

  function automatic blk_t next_key(input blk_t rk, input logic [7:0] rc);
    blk_t   o;
    logic [31:0] t;
    t = {SBOX[get_byte(rk, 13)] ^ rc, SBOX[get_byte(rk, 14)],
         SBOX[get_byte(rk, 15)], SBOX[get_byte(rk, 12)]};
    o[127:96] = rk[127:96] ^ t;
    o[95:64]  = rk[95:64] ^ o[127:96];
    o[63:32]  = rk[63:32] ^ o[95:64];
    o[31:0]   = rk[31:0] ^ o[63:32];
    return o;
  endfunction

  // SubBytes then ShiftRows; optional MixColumns.
  function automatic blk_t round_fn(input blk_t st, input logic last);
    blk_t t;
    blk_t o;
    logic [7:0] a0, a1, a2, a3, d0, d1, d2, d3;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8 * (r + 4 * c) -: 8] = SBOX[get_byte(st, r + 4 * ((c + r) % 4))];
      end
    end
    o = t;
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = get_byte(t, 4 * c);
        a1 = get_byte(t, 4 * c + 1);
        a2 = get_byte(t, 4 * c + 2);
        a3 = get_byte(t, 4 * c + 3);
        d0 = gf_double(a0);
        d1 = gf_double(a1);
        d2 = gf_double(a2);
        d3 = gf_double(a3);
        o[127 - 32 * c -: 32] = {d0 ^ d1 ^ a1 ^ a2 ^ a3, a0 ^ d1 ^ d2 ^ a2 ^ a3,
                                  a0 ^ a1 ^ d2 ^ d3 ^ a3, d0 ^ a0 ^ a1 ^ a2 ^ d3};
      end
    end
    return o;
  endfunction

endpackage

FILE: design/aes_round.sv
// Registered AES round: SubBytes, ShiftRows, MixColumns unless last, key schedule.
`timescale 1ns / 1ps
module aes_round (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              last,
  input  logic [7:0]        rcon,
  input  logic              vld_in,
  input  aes_pkg::blk_t     st_in,
  input  aes_pkg::blk_t     key_in,
  output logic              vld_out,
  output aes_pkg::blk_t     st_out,
  output aes_pkg::blk_t     key_out
);
  import aes_pkg::*;

  logic  vld_r;
  blk_t  st_r;
  blk_t  key_r;
  blk_t  key_nxt;

  assign key_nxt = next_key(key_in, rcon);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      key_r <= key_nxt;
      st_r  <= round_fn(st_in, last) ^ key_nxt;
    end
  end

  assign vld_out = vld_r;
  assign st_out  = st_r;
  assign key_out = key_r;
endmodule

FILE: design/aes128_block_encrypt_top.sv
// Top level of the pipelined AES-128 block encryptor with its key registers.
`timescale 1ns / 1ps
// Pipeline: one register for the initial AddRoundKey, then one register per round for
// ten rounds; out_valid comes from the last round register.
// Throughput: one item per cycle; the round pipeline advances whenever the output
// register is empty or being taken, so a stall holds every stage in place.
// Reset (synchronous, active low) clears all stage valid bits and both key registers.
module aes128_block_encrypt_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_data_high,
  input  logic [63:0] in_data_low,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_cipher_high,
  output logic [63:0] out_cipher_low,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);
  import aes_pkg::*;

  logic [63:0] key_high_r;
  logic [63:0] key_low_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  // Key registers; writes to unknown addresses are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
    end else if (cfg_wr) begin
      if (cfg_paddr == AddrKeyHigh) begin
        key_high_r <= cfg_pwdata;
      end else if (cfg_paddr == AddrKeyLow) begin
        key_low_r <= cfg_pwdata;
      end
    end
  end

  always_comb begin
    case (cfg_paddr)
      AddrKeyHigh: cfg_prdata = key_high_r;
      AddrKeyLow:  cfg_prdata = key_low_r;
      default:     cfg_prdata = '0;
    endcase
  end

  // The whole pipeline moves together: it advances when the final stage is
  // empty or its item is being taken.
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Stage 0: initial AddRoundKey, with the key carried along for expansion.
  logic vld0_r;
  blk_t st0_r;
  blk_t key0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else if (en) begin
      vld0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st0_r  <= {in_data_high, in_data_low} ^ {key_high_r, key_low_r};
      key0_r <= {key_high_r, key_low_r};
    end
  end

  logic vld_s [NumRounds + 1];
  blk_t st_s  [NumRounds + 1];
  blk_t key_s [NumRounds + 1];

  assign vld_s[0] = vld0_r;
  assign st_s[0]  = st0_r;
  assign key_s[0] = key0_r;

  for (genvar g = 0; g < NumRounds; g++) begin : g_round
    aes_round u_round (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .last    (g == NumRounds - 1),
      .rcon    (RCON[g]),
      .vld_in  (vld_s[g]),
      .st_in   (st_s[g]),
      .key_in  (key_s[g]),
      .vld_out (vld_s[g + 1]),
      .st_out  (st_s[g + 1]),
      .key_out (key_s[g + 1])
    );
  end

  assign out_valid       = vld_s[NumRounds];
  assign out_cipher_high = st_s[NumRounds][127:64];
  assign out_cipher_low  = st_s[NumRounds][63:0];
endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the pipelined AES-128 block encryptor.
`timescale 1ns / 1ps
module tb_top;
  import aes_pkg::*;

  // Registers a block passes through from input acceptance to output valid.
  localparam int PipeDepth = 11;
  localparam int DrainCycles = 4 * PipeDepth;
  // Idle cycles with no accepted item before the run is declared hung.
  localparam int WatchdogLimit = 5000;
  localparam int RandomBlocks = 1750;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [63:0] in_data_high = '0;
  logic [63:0] in_data_low = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_cipher_high;
  logic [63:0] out_cipher_low;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [63:0] cfg_pwdata = '0;
  logic [63:0] cfg_prdata;
  logic        cfg_pready;

  aes128_block_encrypt_top dut (.*);

  always #1 clk = ~clk;

  // The testbench's own copy of the key registers.
  logic [63:0] key_hi_q = '0;
  logic [63:0] key_lo_q = '0;

  // Ciphertext blocks still owed by the block, oldest first.
  logic [127:0] cipher_queue[$];
  int  fail_count = 0;
  int  idle_cycles = 0;
  bit  stim_done = 1'b0;
  // While set, the receiver holds off so the pipeline fills and in_ready drops.
  bit  long_hold = 1'b0;

  typedef logic [7:0] byte_arr_t [16];

  const logic [7:0] sub_tab [256] = '{
    8'h63, 8'h7C, 8'h77, 8'h7B, 8'hF2, 8'h6B, 8'h6F, 8'hC5, 8'h30, 8'h01, 8'h67, 8'h2B,
    8'hFE, 8'hD7, 8'hAB, 8'h76, 8'hCA, 8'h82, 8'hC9, 8'h7D, 8'hFA, 8'h59, 8'h47, 8'hF0,
    8'hAD, 8'hD4, 8'hA2, 8'hAF, 8'h9C, 8'hA4, 8'h72, 8'hC0, 8'hB7, 8'hFD, 8'h93, 8'h26,
    8'h36, 8'h3F, 8'hF7, 8'hCC, 8'h34, 8'hA5, 8'hE5, 8'hF1, 8'h71, 8'hD8, 8'h31, 8'h15,
    8'h04, 8'hC7, 8'h23, 8'hC3, 8'h18, 8'h96, 8'h05, 8'h9A, 8'h07, 8'h12, 8'h80, 8'hE2,
    8'hEB, 8'h27, 8'hB2, 8'h75, 8'h09, 8'h83, 8'h2C, 8'h1A, 8'h1B, 8'h6E, 8'h5A, 8'hA0,
    8'h52, 8'h3B, 8'hD6, 8'hB3, 8'h29, 8'hE3, 8'h2F, 8'h84, 8'h53, 8'hD1, 8'h00, 8'hED,
    8'h20, 8'hFC, 8'hB1, 8'h5B, 8'h6A, 8'hCB, 8'hBE, 8'h39, 8'h4A, 8'h4C, 8'h58, 8'hCF,
    8'hD0, 8'hEF, 8'hAA, 8'hFB, 8'h43, 8'h4D, 8'h33, 8'h85, 8'h45, 8'hF9, 8'h02, 8'h7F,
    8'h50, 8'h3C, 8'h9F, 8'hA8, 8'h51, 8'hA3, 8'h40, 8'h8F, 8'h92, 8'h9D, 8'h38, 8'hF5,
    8'hBC, 8'hB6, 8'hDA, 8'h21, 8'h10, 8'hFF, 8'hF3, 8'hD2, 8'hCD, 8'h0C, 8'h13, 8'hEC,
    8'h5F, 8'h97, 8'h44, 8'h17, 8'hC4, 8'hA7, 8'h7E, 8'h3D, 8'h64, 8'h5D, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4F, 8'hDC, 8'h22, 8'h2A, 8'h90, 8'h88, 8'h46, 8'hEE, 8'hB8, 8'h14,
    8'hDE, 8'h5E, 8'h0B, 8'hDB, 8'hE0, 8'h32, 8'h3A, 8'h0A, 8'h49, 8'h06, 8'h24, 8'h5C,
    8'hC2, 8'hD3, 8'hAC, 8'h62, 8'h91, 8'h95, 8'hE4, 8'h79, 8'hE7, 8'hC8, 8'h37, 8'h6D,
    8'h8D, 8'hD5, 8'h4E, 8'hA9, 8'h6C, 8'h56, 8'hF4, 8'hEA, 8'h65, 8'h7A, 8'hAE, 8'h08,
    8'hBA, 8'h78, 8'h25, 8'h2E, 8'h1C, 8'hA6, 8'hB4, 8'hC6, 8'hE8, 8'hDD, 8'h74, 8'h1F,
    8'h4B, 8'hBD, 8'h8B, 8'h8A, 8'h70, 8'h3E, 8'hB5, 8'h66, 8'h48, 8'h03, 8'hF6, 8'h0E,
    8'h61, 8'h35, 8'h57, 8'hB9, 8'h86, 8'hC1, 8'h1D, 8'h9E, 8'hE1, 8'hF8, 8'h98, 8'h11,
    8'h69, 8'hD9, 8'h8E, 8'h94, 8'h9B, 8'h1E, 8'h87, 8'hE9, 8'hCE, 8'h55, 8'h28, 8'hDF,
    8'h8C, 8'hA1, 8'h89, 8'h0D, 8'hBF, 8'hE6, 8'h42, 8'h68, 8'h41, 8'h99, 8'h2D, 8'h0F,
    8'hB0, 8'h54, 8'hBB, 8'h16
  };

  function automatic logic [7:0] xtime(logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1B : 8'h00);
  endfunction

  // Full AES-128 encryption of one block under the current key copy.
  function automatic logic [127:0] aes_encrypt(logic [127:0] plain);
    byte_arr_t st, rk, sh;
    logic [7:0] rcon, t0, t1, t2, t3, a0, a1, a2, a3;
    logic [127:0] res;
    logic [127:0] kb;
    kb = {key_hi_q, key_lo_q};
    rcon = 8'h01;
    for (int i = 0; i < 16; i++) begin
      st[i] = plain[127 - 8 * i -: 8] ^ kb[127 - 8 * i -: 8];
      rk[i] = kb[127 - 8 * i -: 8];
    end
    for (int rnd = 1; rnd <= 10; rnd++) begin
      // SubBytes and ShiftRows together; index is row + 4 * column.
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          sh[r + 4 * c] = sub_tab[st[r + 4 * ((c + r) % 4)]];
      st = sh;
      if (rnd < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = sh[4 * c]; a1 = sh[4 * c + 1]; a2 = sh[4 * c + 2]; a3 = sh[4 * c + 3];
          st[4 * c]     = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
          st[4 * c + 1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
          st[4 * c + 2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
          st[4 * c + 3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
        end
      end
      t0 = sub_tab[rk[13]] ^ rcon;
      t1 = sub_tab[rk[14]];
      t2 = sub_tab[rk[15]];
      t3 = sub_tab[rk[12]];
      rk[0] ^= t0; rk[1] ^= t1; rk[2] ^= t2; rk[3] ^= t3;
      for (int i = 4; i < 16; i++) rk[i] ^= rk[i - 4];
      rcon = xtime(rcon);
      for (int i = 0; i < 16; i++) st[i] ^= rk[i];
    end
    for (int i = 0; i < 16; i++) res[127 - 8 * i -: 8] = st[i];
    return res;
  endfunction

  // One APB write: setup cycle, then the access cycle (pready is always high).
  task automatic reg_write(logic [3:0] addr, logic [63:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (addr == AddrKeyHigh) key_hi_q = value;
    else if (addr == AddrKeyLow) key_lo_q = value;
  endtask

  // Loads both key halves, only after the pipeline has drained.
  task automatic load_key(logic [63:0] hi, logic [63:0] lo);
    in_valid <= 1'b0;
    while (cipher_queue.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    reg_write(AddrKeyHigh, hi);
    reg_write(AddrKeyLow, lo);
  endtask

  // Offers one plaintext item and holds it until accepted. When known is set,
  // the typed-in ciphertext replaces the predicted one. Valid stays high after
  // acceptance so that a following item can go out back to back.
  task automatic send_block(logic [63:0] hi, logic [63:0] lo, bit known = 1'b0,
                            logic [127:0] cipher = '0);
    logic [127:0] pred;
    pred = aes_encrypt({hi, lo});
    if (known && pred != cipher) begin
      $error("predictor disagrees with typed-in ciphertext: exp %h got %h", cipher, pred);
      fail_count++;
    end
    cipher_queue.push_back(known ? cipher : pred);
    in_valid     <= 1'b1;
    in_data_high <= hi;
    in_data_low  <= lo;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic sender_gap();
    int n;
    n = $urandom_range(0, 99);
    if (n < 55) return;
    in_valid <= 1'b0;
    if (n < 95) repeat ($urandom_range(1, 3)) @(posedge clk);
    else repeat ($urandom_range(10, 40)) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Random 64-bit value biased toward extremes and sparse patterns.
  function automatic logic [63:0] pick64();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 64'h1 << $urandom_range(0, 63);
      default: return rand64();
    endcase
  endfunction

  // Directed table. Known rows come from the published AES-128 test vectors.
  typedef struct {
    bit          new_key;
    logic [63:0] k_hi, k_lo;
    logic [63:0] p_hi, p_lo;
    bit          known;
    logic [127:0] cipher;
  } vec_row_t;

  vec_row_t vec_rows[] = '{
    // Zero key left by reset, zero plaintext.
    '{1'b0, 64'h0, 64'h0, 64'h0, 64'h0, 1'b1, 128'h66e94bd4ef8a2c3b884cfa59ca342b2e},
    '{1'b0, 64'h0, 64'h0, '1, '1, 1'b0, '0},
    '{1'b0, 64'h0, 64'h0, 64'h8000000000000000, 64'h0, 1'b0, '0},
    '{1'b0, 64'h0, 64'h0, 64'h0, 64'h1, 1'b0, '0},
    // FIPS-197 appendix C.1 vector.
    '{1'b1, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
      64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1,
      128'h69c4e0d86a7b0430d8cdb78070b4c55a},
    '{1'b0, 64'h0, 64'h0, 64'h0, 64'h0, 1'b0, '0},
    '{1'b0, 64'h0, 64'h0, '1, 64'h0, 1'b0, '0},
    // FIPS-197 appendix B vector.
    '{1'b1, 64'h2b7e151628aed2a6, 64'habf7158809cf4f3c,
      64'h3243f6a8885a308d, 64'h313198a2e0370734, 1'b1,
      128'h3925841d02dc09fbdc118597196a0b32},
    // All-ones key.
    '{1'b1, '1, '1, 64'h0, 64'h0, 1'b0, '0},
    '{1'b0, 64'h0, 64'h0, '1, '1, 1'b0, '0},
    '{1'b0, 64'h0, 64'h0, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b0, '0},
    '{1'b1, 64'h8000000000000000, 64'h1, 64'h0123456789abcdef, 64'hfedcba9876543210,
      1'b0, '0}
  };

  // Input side: directed table, then random phases with new keys between them.
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (vec_rows[i]) begin
      if (vec_rows[i].new_key) load_key(vec_rows[i].k_hi, vec_rows[i].k_lo);
      send_block(vec_rows[i].p_hi, vec_rows[i].p_lo, vec_rows[i].known,
                 vec_rows[i].cipher);
    end
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: load_key('0, '0);
        1: load_key('1, '1);
        2: load_key(rand64(), '0);
        default: load_key(pick64(), pick64());
      endcase
      for (int n = 0; n < RandomBlocks / 7; n++) begin
        // One back-to-back burst in phase 3 while the receiver is held off.
        if (ph == 3 && n == 20) long_hold = 1'b1;
        send_block(pick64(), pick64());
        if (!(ph == 3 && n >= 20 && n < 60)) sender_gap();
      end
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver: random stalls, plus one long hold-off counted here.
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (60) @(posedge clk);
        long_hold = 1'b0;
      end else begin
        n = $urandom_range(0, 99);
        if (n < 60) begin
          out_ready <= 1'b1;
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end else if (n < 95) begin
          out_ready <= 1'b0;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else begin
          out_ready <= 1'b0;
          repeat ($urandom_range(10, 40)) @(posedge clk);
        end
      end
    end
  end

  // Scoreboard: compare each accepted item with the oldest expectation.
  always @(posedge clk) begin
    logic [127:0] exp_blk;
    if (rst_n && out_valid && out_ready) begin
      if (cipher_queue.size() == 0) begin
        $error("unexpected item: cipher_high %h cipher_low %h",
               out_cipher_high, out_cipher_low);
        fail_count++;
      end else begin
        exp_blk = cipher_queue.pop_front();
        if (out_cipher_high !== exp_blk[127:64]) begin
          $error("cipher_high exp %h got %h", exp_blk[127:64], out_cipher_high);
          fail_count++;
        end
        if (out_cipher_low !== exp_blk[63:0]) begin
          $error("cipher_low exp %h got %h", exp_blk[63:0], out_cipher_low);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: counts cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // End of run: drain the queue, then keep watching for stray items before the verdict.
  initial begin
    wait (stim_done);
    while (cipher_queue.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0 && cipher_queue.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
